[rtl/assert_macros.svh]
// Assertion macros shared by the transmitter RTL.
// Depends on the including module having i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define AST_PROP(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("utx assertion failed");

// Checks that a condition never holds outside of reset.
`define AST_NEVER(label, expr) \
    `AST_PROP(label, !(expr))

`endif

[rtl/utx_pkg.sv]
// Shared constants and types for the UART transmitter with FIFO.
// No dependencies; used by utx_fifo and uart_transmitter_with_fifo.
package utx_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_DATA_BITS   = 2'd0;
    localparam logic [1:0] REG_PARITY_MODE = 2'd1;
    localparam logic [1:0] REG_STOP_BITS   = 2'd2;

    localparam logic [3:0] DATA_BITS_RESET = 4'd8;
    localparam logic [3:0] DATA_BITS_MIN   = 4'd5;
    localparam logic [3:0] DATA_BITS_MAX   = 4'd8;

    localparam logic [2:0] PAR_NONE  = 3'd0;
    localparam logic [2:0] PAR_ODD   = 3'd1;
    localparam logic [2:0] PAR_EVEN  = 3'd2;
    localparam logic [2:0] PAR_MARK  = 3'd3;
    localparam logic [2:0] PAR_SPACE = 3'd4;

    localparam logic [1:0] STOP_ONE = 2'd1;
    localparam logic [1:0] STOP_TWO = 2'd2;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [4:0] LEVEL_MAX = 5'd31;
    localparam logic [3:0] FRAME_MAX = 4'd11;

    typedef struct packed {
        logic                  full;
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_status;

    typedef struct packed {
        logic       line_level;
        logic       accepted;
        logic [4:0] fifo_level;
        logic       busy_res;
    } t_result;

endpackage

[rtl/utx_fifo.sv]
// Byte FIFO with head-of-queue read for the UART transmitter.
// Depends on utx_pkg for depth, pointer and count widths.
module utx_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_push_data,
    input  logic                  i_pop,
    output logic [7:0]            o_head,
    output utx_pkg::t_fifo_status o_status
);

    logic [7:0]                     r_store [utx_pkg::FIFO_DEPTH];
    logic [7:0]                     r_head;
    logic [utx_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [utx_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [utx_pkg::FIFO_CNT_W-1:0] r_count;
    logic [utx_pkg::FIFO_PTR_W-1:0] n_rd_ptr;
    logic [utx_pkg::FIFO_PTR_W-1:0] n_wr_ptr;

    localparam logic [utx_pkg::FIFO_PTR_W-1:0] PTR_LAST =
        utx_pkg::FIFO_PTR_W'(utx_pkg::FIFO_DEPTH - 1);

    always_comb begin
        n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_push_data;
        end
    end

    // The oldest byte is kept in a register so that it is ready on the cycle of a pop.
    always_ff @(posedge i_clk) begin
        if (i_push && ((r_count == '0) || (i_pop && (r_count == 1)))) begin
            r_head <= i_push_data;
        end else if (i_pop) begin
            r_head <= r_store[n_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head         = r_head;
    assign o_status.count = r_count;
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == utx_pkg::FIFO_CNT_W'(utx_pkg::FIFO_DEPTH));

endmodule

[rtl/uart_transmitter_with_fifo.sv]
// Results are registered; a two-entry output stage absorbs one stalled result.
// Throughput: one item per cycle while the input is not stalled.
// Input stall rises only when both output entries are full.
// Reset (synchronous, active low) empties the FIFO, idles the line high and
// restores 8 data bits, no parity and one stop bit.
// Depends on utx_pkg, utx_fifo and assert_macros.svh.
`include "assert_macros.svh"

module uart_transmitter_with_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [7:0]                  i_data_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_line_level,
    output logic                        o_accepted,
    output logic [4:0]                  o_fifo_level,
    output logic                        o_busy_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [utx_pkg::PADDR_W-1:0] paddr,
    input  logic [utx_pkg::PDATA_W-1:0] pwdata,
    output logic [utx_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [3:0] r_data_bits;
    logic [2:0] r_parity_mode;
    logic [1:0] r_stop_bits;

    logic [7:0] r_shift;
    logic [3:0] r_bits_left;
    logic       r_parity;
    logic       r_line;
    logic [7:0] n_shift;
    logic [3:0] n_bits_left;
    logic       n_parity;
    logic       n_line;

    logic             r_out_valid;
    logic             r_skid_valid;
    utx_pkg::t_result r_out;
    utx_pkg::t_result r_skid;
    utx_pkg::t_result n_result;

    logic                          in_accept;
    logic                          out_take;
    logic                          cfg_write;
    logic                          push;
    logic                          pop;
    logic [7:0]                    head;
    utx_pkg::t_fifo_status         fifo_status;
    logic [utx_pkg::FIFO_CNT_W-1:0] n_count;

    logic [3:0] eff_data;
    logic [2:0] eff_parity;
    logic [1:0] eff_stop;
    logic       has_parity;
    logic [3:0] frame_len;

    utx_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (i_data_byte),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (fifo_status)
    );

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_take  = r_out_valid && !i_out_stall;
    assign cfg_write = psel && penable && pwrite;
    assign push      = in_accept && (i_func == utx_pkg::FUNC_WRITE) && !fifo_status.full;

    always_comb begin
        if (r_data_bits < utx_pkg::DATA_BITS_MIN) begin
            eff_data = utx_pkg::DATA_BITS_MIN;
        end else if (r_data_bits > utx_pkg::DATA_BITS_MAX) begin
            eff_data = utx_pkg::DATA_BITS_MAX;
        end else begin
            eff_data = r_data_bits;
        end
        eff_parity = (r_parity_mode > utx_pkg::PAR_SPACE) ? utx_pkg::PAR_NONE : r_parity_mode;
        has_parity = (eff_parity != utx_pkg::PAR_NONE);
        if (r_stop_bits < utx_pkg::STOP_ONE) begin
            eff_stop = utx_pkg::STOP_ONE;
        end else if (r_stop_bits > utx_pkg::STOP_TWO) begin
            eff_stop = utx_pkg::STOP_TWO;
        end else begin
            eff_stop = r_stop_bits;
        end
        frame_len = eff_data + {3'b000, has_parity} + {2'b00, eff_stop};
    end

    // Bit sequencer: one tick moves the frame forward by one bit time.
    always_comb begin
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_parity    = r_parity;
        n_line      = r_line;
        pop         = 1'b0;
        if (in_accept && (i_func == utx_pkg::FUNC_TICK)) begin
            if (r_bits_left == 4'd0) begin
                if (!fifo_status.empty) begin
                    pop         = 1'b1;
                    n_shift     = head;
                    n_line      = 1'b0;
                    n_parity    = 1'b0;
                    n_bits_left = frame_len;
                end
            end else begin
                if (r_bits_left <= {2'b00, eff_stop}) begin
                    n_line = 1'b1;
                end else if (has_parity && (r_bits_left == {2'b00, eff_stop} + 4'd1)) begin
                    case (eff_parity)
                        utx_pkg::PAR_ODD:  n_line = ~r_parity;
                        utx_pkg::PAR_EVEN: n_line = r_parity;
                        utx_pkg::PAR_MARK: n_line = 1'b1;
                        default:           n_line = 1'b0;
                    endcase
                end else begin
                    n_line   = r_shift[0];
                    n_parity = r_parity ^ r_shift[0];
                    n_shift  = {1'b0, r_shift[7:1]};
                end
                n_bits_left = r_bits_left - 4'd1;
            end
        end
    end

    always_comb begin
        n_count = fifo_status.count;
        if (push) begin
            n_count = fifo_status.count + 1'b1;
        end else if (pop) begin
            n_count = fifo_status.count - 1'b1;
        end
        n_result.line_level = n_line;
        n_result.accepted   = push;
        n_result.fifo_level = (32'(n_count) > 32'(utx_pkg::LEVEL_MAX)) ?
                              utx_pkg::LEVEL_MAX : 5'(n_count);
        n_result.busy_res   = (n_bits_left != 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_bits_left <= '0;
            r_parity    <= 1'b0;
            r_line      <= 1'b1;
        end else begin
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_parity    <= n_parity;
            r_line      <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_bits   <= utx_pkg::DATA_BITS_RESET;
            r_parity_mode <= utx_pkg::PAR_NONE;
            r_stop_bits   <= utx_pkg::STOP_ONE;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                utx_pkg::REG_DATA_BITS:   r_data_bits   <= pwdata[3:0];
                utx_pkg::REG_PARITY_MODE: r_parity_mode <= pwdata[2:0];
                utx_pkg::REG_STOP_BITS:   r_stop_bits   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            utx_pkg::REG_DATA_BITS:   prdata = {28'd0, r_data_bits};
            utx_pkg::REG_PARITY_MODE: prdata = {29'd0, r_parity_mode};
            utx_pkg::REG_STOP_BITS:   prdata = {30'd0, r_stop_bits};
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end else if (in_accept) begin
            r_skid <= n_result;
        end
    end

    assign o_in_stall   = r_skid_valid;
    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_out.line_level;
    assign o_accepted   = r_out.accepted;
    assign o_fifo_level = r_out.fifo_level;
    assign o_busy_res   = r_out.busy_res;

    `AST_PROP(a_skid_needs_out, r_skid_valid |-> r_out_valid)
    `AST_NEVER(a_count_bound, 32'(fifo_status.count) > utx_pkg::FIFO_DEPTH)
    `AST_NEVER(a_frame_bound, r_bits_left > utx_pkg::FRAME_MAX)
    `AST_PROP(a_idle_line_high, (r_bits_left == 4'd0) |-> r_line)

endmodule
